>>> hw/rtl/csm_pkg.sv
package csm_pkg;

    localparam int MAX_DIVISIONS = 255;
    localparam int IDX_W         = 19;
    localparam int K_W           = 9;
    localparam int SUMSQ_W       = 18;
    localparam int DIV_STEPS     = 34;
    localparam int SQ_STEPS      = 17;
    localparam int LANE_LAT      = 2 + DIV_STEPS + SQ_STEPS;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int NUM_FACES     = 6;

    localparam logic REG_DIVISIONS = 1'b0;
    localparam logic REG_RADIUS    = 1'b1;

    localparam logic [7:0]  DIVISIONS_RESET = 8'd16;
    localparam logic [15:0] RADIUS_RESET    = 16'd256;

    typedef logic signed [1:0] unit_t;

    localparam unit_t ORG_TAB [NUM_FACES][3] = '{
        '{-2'sd1, -2'sd1, -2'sd1}, '{ 2'sd1, -2'sd1, -2'sd1}, '{ 2'sd1, -2'sd1,  2'sd1},
        '{-2'sd1, -2'sd1,  2'sd1}, '{-2'sd1,  2'sd1, -2'sd1}, '{-2'sd1, -2'sd1,  2'sd1}
    };
    localparam unit_t RGT_TAB [NUM_FACES][3] = '{
        '{ 2'sd1,  2'sd0,  2'sd0}, '{ 2'sd0,  2'sd0,  2'sd1}, '{-2'sd1,  2'sd0,  2'sd0},
        '{ 2'sd0,  2'sd0, -2'sd1}, '{ 2'sd1,  2'sd0,  2'sd0}, '{ 2'sd1,  2'sd0,  2'sd0}
    };
    localparam unit_t UP_TAB [NUM_FACES][3] = '{
        '{ 2'sd0,  2'sd1,  2'sd0}, '{ 2'sd0,  2'sd1,  2'sd0}, '{ 2'sd0,  2'sd1,  2'sd0},
        '{ 2'sd0,  2'sd1,  2'sd0}, '{ 2'sd0,  2'sd0,  2'sd1}, '{ 2'sd0,  2'sd0, -2'sd1}
    };

    typedef struct packed {
        logic             func;
        logic             err;
        logic             diag;
        logic [IDX_W-1:0] a;
        logic [K_W-1:0]   k;
        logic [2:0]       sgn;
    } csm_tag_t;

    typedef struct packed {
        csm_tag_t             tag;
        logic [2:0][7:0]      qabs;
        logic [SUMSQ_W-1:0]   sumsq;
    } csm_desc_t;

    function automatic logic signed [11:0] unit_mul(unit_t u, logic [9:0] v);
        logic signed [11:0] r;
        unique case (u)
            2'sd1:   r = $signed({2'b00, v});
            -2'sd1:  r = -$signed({2'b00, v});
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/csm_ifs.sv
interface csm_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [2:0] face;
    logic [7:0] row;
    logic [7:0] col;
    modport source (output valid, func, face, row, col, input ready);
    modport sink   (input valid, func, face, row, col, output ready);
endinterface

interface csm_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [18:0]        corner_first;
    logic [18:0]        corner_second;
    logic [18:0]        corner_third;
    logic               last;
    logic               error;
    modport source (output valid, pos_x, pos_y, pos_z, corner_first, corner_second,
                    corner_third, last, error, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, corner_first, corner_second,
                    corner_third, last, error, output ready);
endinterface

interface csm_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/csm_front.sv
module csm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          divisions,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                func,
    input  logic [2:0]          face,
    input  logic [7:0]          row,
    input  logic [7:0]          col,
    output logic                push,
    input  logic                push_ready,
    output csm_pkg::csm_desc_t  desc
);
    import csm_pkg::*;

    logic               fv_reg;
    logic               fv_next;
    csm_desc_t          desc_reg;
    csm_desc_t          desc_next;
    logic [7:0]         d;
    logic [7:0]         half;
    logic [K_W-1:0]     k;
    logic [2:0]         fidx;
    logic               bad_face;
    logic [11:0]        fk;
    logic [20:0]        a_full;
    logic signed [11:0] q [3];
    logic [11:0]        qmag [3];
    logic [15:0]        sq [3];

    always_comb
    begin
        d = divisions;
        if (d == 8'd0)
            d = 8'd1;
        if (10'(d) > 10'(MAX_DIVISIONS))
            d = 8'(MAX_DIVISIONS);
        half     = d >> 1;
        k        = {1'b0, d} + 9'd1;
        bad_face = face > 3'(NUM_FACES - 1);
        fidx     = bad_face ? 3'd0 : face;
        fk       = 12'(face) * 12'(k);
        a_full   = 21'(fk + 12'(row)) * 21'(k) + 21'(col);

        for (int c = 0; c < 3; c++)
        begin
            q[c] = unit_mul(ORG_TAB[fidx][c], {2'b00, d})
                 + unit_mul(RGT_TAB[fidx][c], {1'b0, col, 1'b0})
                 + unit_mul(UP_TAB[fidx][c], {1'b0, row, 1'b0});
            qmag[c] = q[c][11] ? 12'(-q[c]) : 12'(q[c]);
            sq[c]   = qmag[c][7:0] * qmag[c][7:0];
        end

        desc_next.tag.func = func;
        if (func)
            desc_next.tag.err = bad_face || row >= d || col >= d;
        else
            desc_next.tag.err = bad_face || row > d || col > d;
        desc_next.tag.diag = (row < half) != (col < half);
        desc_next.tag.a    = a_full[IDX_W-1:0];
        desc_next.tag.k    = k;
        desc_next.tag.sgn  = {q[2][11], q[1][11], q[0][11]};
        desc_next.qabs     = {qmag[2][7:0], qmag[1][7:0], qmag[0][7:0]};
        desc_next.sumsq    = SUMSQ_W'(sq[0]) + SUMSQ_W'(sq[1]) + SUMSQ_W'(sq[2]);

        in_ready = !fv_reg || push_ready;
        fv_next  = fv_reg;
        if (in_ready)
            fv_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else
            fv_reg <= fv_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            desc_reg <= desc_next;
    end

    assign push = fv_reg;
    assign desc = desc_reg;

endmodule

>>> hw/rtl/csm_fifo.sv
module csm_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  csm_pkg::csm_desc_t  wr_data,
    output logic                rd_valid,
    input  logic                rd_ready,
    output csm_pkg::csm_desc_t  rd_data
);
    import csm_pkg::*;

    csm_desc_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wp_reg;
    logic [FIFO_AW-1:0] wp_next;
    logic [FIFO_AW-1:0] rp_reg;
    logic [FIFO_AW-1:0] rp_next;
    logic [FIFO_AW:0]   cnt_reg;
    logic [FIFO_AW:0]   cnt_next;
    logic               wr;
    logic               rd;

    always_comb
    begin
        wr_ready = cnt_reg != (FIFO_AW+1)'(FIFO_DEPTH);
        rd_valid = cnt_reg != '0;
        wr       = wr_valid && wr_ready;
        rd       = rd_valid && rd_ready;
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (wr)
            wp_next = (wp_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        if (rd)
            rp_next = (rp_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        if (wr && !rd)
            cnt_next = cnt_reg + 1'b1;
        else if (rd && !wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    assign rd_data = mem_reg[rp_reg];

endmodule

>>> hw/rtl/csm_lane.sv
module csm_lane (
    input  logic                        clk,
    input  logic                        en,
    input  logic [7:0]                  qabs,
    input  logic [csm_pkg::SUMSQ_W-1:0] sumsq,
    input  logic [15:0]                 radius,
    output logic [16:0]                 mag
);
    import csm_pkg::*;

    logic [23:0]        m_reg;
    logic [SUMSQ_W-1:0] s0_reg;
    logic [49:0]        n_reg;
    logic [SUMSQ_W-1:0] s1_reg;

    logic [SUMSQ_W-1:0] rem_reg  [DIV_STEPS];
    logic [33:0]        nlo_reg  [DIV_STEPS];
    logic [33:0]        quo_reg  [DIV_STEPS];
    logic [SUMSQ_W-1:0] dq_reg   [DIV_STEPS];
    logic [SUMSQ_W-1:0] rem_in   [DIV_STEPS];
    logic [33:0]        nlo_in   [DIV_STEPS];
    logic [33:0]        quo_in   [DIV_STEPS];
    logic [SUMSQ_W-1:0] dq_in    [DIV_STEPS];
    logic [SUMSQ_W-1:0] rem_next [DIV_STEPS];
    logic [33:0]        nlo_next [DIV_STEPS];
    logic [33:0]        quo_next [DIV_STEPS];

    logic [33:0]        v_reg  [SQ_STEPS];
    logic [33:0]        r_reg  [SQ_STEPS];
    logic [33:0]        v_in   [SQ_STEPS];
    logic [33:0]        r_in   [SQ_STEPS];
    logic [33:0]        v_next [SQ_STEPS];
    logic [33:0]        r_next [SQ_STEPS];

    // restoring divide, one quotient bit per stage
    always_comb
    begin
        logic [SUMSQ_W:0] t;
        rem_in[0] = {2'b00, n_reg[49:34]};
        nlo_in[0] = n_reg[33:0];
        quo_in[0] = '0;
        dq_in[0]  = s1_reg;
        for (int i = 1; i < DIV_STEPS; i++)
        begin
            rem_in[i] = rem_reg[i-1];
            nlo_in[i] = nlo_reg[i-1];
            quo_in[i] = quo_reg[i-1];
            dq_in[i]  = dq_reg[i-1];
        end
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            t = {rem_in[i], nlo_in[i][33]};
            if (t >= {1'b0, dq_in[i]})
            begin
                rem_next[i] = SUMSQ_W'(t - {1'b0, dq_in[i]});
                quo_next[i] = {quo_in[i][32:0], 1'b1};
            end
            else
            begin
                rem_next[i] = t[SUMSQ_W-1:0];
                quo_next[i] = {quo_in[i][32:0], 1'b0};
            end
            nlo_next[i] = {nlo_in[i][32:0], 1'b0};
        end
    end

    // digit-by-digit square root, one result bit per stage
    always_comb
    begin
        logic [33:0] bitv;
        logic [33:0] rb;
        v_in[0] = quo_reg[DIV_STEPS-1];
        r_in[0] = '0;
        for (int j = 1; j < SQ_STEPS; j++)
        begin
            v_in[j] = v_reg[j-1];
            r_in[j] = r_reg[j-1];
        end
        for (int j = 0; j < SQ_STEPS; j++)
        begin
            bitv = 34'd1 << (2 * (SQ_STEPS - 1 - j));
            rb   = r_in[j] + bitv;
            if (v_in[j] >= rb)
            begin
                v_next[j] = v_in[j] - rb;
                r_next[j] = (r_in[j] >> 1) + bitv;
            end
            else
            begin
                v_next[j] = v_in[j];
                r_next[j] = r_in[j] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg   <= 24'(radius) * 24'(qabs);
            s0_reg  <= sumsq;
            n_reg   <= {48'(m_reg) * 48'(m_reg), 2'b00};
            s1_reg  <= s0_reg;
            rem_reg <= rem_next;
            nlo_reg <= nlo_next;
            quo_reg <= quo_next;
            dq_reg  <= dq_in;
            v_reg   <= v_next;
            r_reg   <= r_next;
        end
    end

    assign mag = 17'((r_reg[SQ_STEPS-1] + 34'd1) >> 1);

endmodule

>>> hw/rtl/csm_back.sv
module csm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         radius,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  csm_pkg::csm_desc_t  desc,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         pos_x,
    output logic [15:0]         pos_y,
    output logic [15:0]         pos_z,
    output logic [18:0]         corner_first,
    output logic [18:0]         corner_second,
    output logic [18:0]         corner_third,
    output logic                last,
    output logic                error
);
    import csm_pkg::*;

    logic               adv;
    logic               vld_reg [LANE_LAT];
    logic               vld_next [LANE_LAT];
    csm_tag_t           tag_reg [LANE_LAT];
    csm_tag_t           tag_next [LANE_LAT];
    logic [16:0]        mag [3];
    logic [15:0]        sat [3];

    logic               ov_reg;
    logic               ov_next;
    logic               ph_reg;
    logic               ph_next;
    csm_tag_t           otag_reg;
    logic [2:0][15:0]   opos_reg;
    logic               obeat_last;
    logic [IDX_W-1:0]   ia;
    logic [IDX_W-1:0]   ib;
    logic [IDX_W-1:0]   ic;
    logic [IDX_W-1:0]   ie;

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        csm_lane u_lane (
            .clk    (clk),
            .en     (adv),
            .qabs   (desc.qabs[c]),
            .sumsq  (desc.sumsq),
            .radius (radius),
            .mag    (mag[c])
        );
    end

    always_comb
    begin
        obeat_last = !(otag_reg.func && !otag_reg.err && !ph_reg);
        adv        = !ov_reg || (out_ready && obeat_last);
        pop_ready  = adv;

        vld_next[0] = pop_valid;
        tag_next[0] = desc.tag;
        for (int i = 1; i < LANE_LAT; i++)
        begin
            vld_next[i] = vld_reg[i-1];
            tag_next[i] = tag_reg[i-1];
        end

        for (int c = 0; c < 3; c++)
        begin
            if (tag_reg[LANE_LAT-1].func || tag_reg[LANE_LAT-1].err)
                sat[c] = '0;
            else if (tag_reg[LANE_LAT-1].sgn[c])
                sat[c] = (mag[c] > 17'd32768) ? 16'h8000 : 16'(-mag[c]);
            else
                sat[c] = (mag[c] > 17'd32767) ? 16'h7fff : mag[c][15:0];
        end

        ov_next = ov_reg;
        ph_next = ph_reg;
        if (adv)
        begin
            ov_next = vld_reg[LANE_LAT-1];
            ph_next = 1'b0;
        end
        else if (out_ready)
            ph_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_LAT; i++)
                vld_reg[i] <= 1'b0;
            ov_reg <= 1'b0;
            ph_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                vld_reg <= vld_next;
            ov_reg <= ov_next;
            ph_reg <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg  <= tag_next;
            otag_reg <= tag_reg[LANE_LAT-1];
            opos_reg <= {sat[2], sat[1], sat[0]};
        end
    end

    always_comb
    begin
        ia = otag_reg.a;
        ib = otag_reg.a + 1'b1;
        ic = otag_reg.a + IDX_W'(otag_reg.k);
        ie = otag_reg.a + IDX_W'(otag_reg.k) + 1'b1;

        out_valid = ov_reg;
        pos_x     = opos_reg[0];
        pos_y     = opos_reg[1];
        pos_z     = opos_reg[2];
        last      = obeat_last;
        error     = otag_reg.err;
        corner_first  = '0;
        corner_second = '0;
        corner_third  = '0;
        if (otag_reg.func && !otag_reg.err)
        begin
            if (otag_reg.diag)
            begin
                corner_first  = ph_reg ? ic : ia;
                corner_second = ph_reg ? ie : ic;
                corner_third  = ib;
            end
            else
            begin
                corner_first  = ia;
                corner_second = ph_reg ? ie : ic;
                corner_third  = ph_reg ? ib : ie;
            end
        end
    end

endmodule

>>> hw/rtl/cube_sphere_mesh_generator_core.sv
// Cube-sphere mesh generator. Vertex beats (func 0) return one signed Q8.8 sphere point
// for grid point (row, col) of a cube face, scaled by radius; quad beats (func 1) return
// two index-triangle beats, the second flagged last. Bad face/row/col yields a single
// beat with error and last set. One beat is accepted per cycle while the queue has room;
// vertex beats leave at one per cycle while the output is ready, a quad request as two
// beats. Beats pass the input register, a queue slot, the 53-stage per-component pipeline
// (two multiply, 34 divide, 17 square-root stages) and the output register. Output stalls
// freeze the pipeline. The user must write registers only while the block is idle; unenforced.
module cube_sphere_mesh_generator_core (
    input  logic      clk,
    input  logic      rst_n,
    csm_req_if.sink   req,
    csm_rsp_if.source rsp,
    csm_cfg_if.sink   cfg
);
    import csm_pkg::*;

    logic [7:0]  divisions_reg;
    logic [15:0] radius_reg;
    logic        push;
    logic        push_ready;
    csm_desc_t   fdesc;
    logic        pop_valid;
    logic        pop_ready;
    csm_desc_t   bdesc;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisions_reg <= DIVISIONS_RESET;
            radius_reg    <= RADIUS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DIVISIONS: divisions_reg <= cfg.data[7:0];
                REG_RADIUS:    radius_reg    <= cfg.data;
                default:       radius_reg    <= radius_reg;
            endcase
        end
    end

    csm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .divisions  (divisions_reg),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .func       (req.func),
        .face       (req.face),
        .row        (req.row),
        .col        (req.col),
        .push       (push),
        .push_ready (push_ready),
        .desc       (fdesc)
    );

    csm_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push),
        .wr_ready (push_ready),
        .wr_data  (fdesc),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (bdesc)
    );

    csm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .radius        (radius_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .desc          (bdesc),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .pos_x         (px),
        .pos_y         (py),
        .pos_z         (pz),
        .corner_first  (rsp.corner_first),
        .corner_second (rsp.corner_second),
        .corner_third  (rsp.corner_third),
        .last          (rsp.last),
        .error         (rsp.error)
    );

    assign rsp.pos_x = $signed(px);
    assign rsp.pos_y = $signed(py);
    assign rsp.pos_z = $signed(pz);

endmodule
